// ===== hdl/matrix_vector_multiply_accumulate_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply-accumulate block
// Each macro expands to one labeled concurrent assertion on a given clock and
// synchronous reset, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_ACCUMULATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MVMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MVMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mvma_pkg.sv =====
// ----------------------------------------------------------------------------
// mvma_pkg
// Widths, codes and shared types of the matrix-vector multiply-accumulate block.
// ----------------------------------------------------------------------------
`default_nettype none

package mvma_pkg;

   localparam int DATA_W      = 16;  // Q8.8 element width
   localparam int IDX_W       = 10;  // vector index field
   localparam int ROW_W       = 10;  // row index field of a result
   localparam int COUNT_W     = 11;  // row and column count registers
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ACC_W       = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 48;  // index + value + prior_y, padded to bytes
   localparam int RSP_TDATA_W = 32;  // y_value + row_index, padded to bytes

   // Item kinds carried on req_tuser
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_MATRIX = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT    = 2'd0,
      CSR_COLUMN_COUNT = 2'd1,
      CSR_ALPHA_SCALE  = 2'd2,
      CSR_BETA_SCALE   = 2'd3
   } csr_index_type;

   // Bookkeeping that travels with a matrix element down the pipeline
   typedef struct packed {
      logic             row_end;
      logic             last;
      logic [ROW_W-1:0] row;
   } row_tag_type;

endpackage

`default_nettype wire

// ===== hdl/mvma_store.sv =====
// ----------------------------------------------------------------------------
// mvma_store
// Vector element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mvma_store #(
   parameter int DEPTH = 1024
) (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire  [$clog2(DEPTH)-1:0]        wr_addr,
   input  wire  [mvma_pkg::DATA_W-1:0]     wr_data,
   input  wire                             rd_en,
   input  wire  [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [mvma_pkg::DATA_W-1:0]     rd_data_ff
);
   import mvma_pkg::*;

   logic [DATA_W-1:0] store_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // Hold the last read word while no new read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mvma_mac.sv =====
// ----------------------------------------------------------------------------
// mvma_mac
// Multiply a matrix element by its vector element and accumulate per row.
// ----------------------------------------------------------------------------
`default_nettype none

module mvma_mac (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  wire                                 s1_valid,
   input  wire  signed [mvma_pkg::DATA_W-1:0]  s1_value,
   input  wire  signed [mvma_pkg::DATA_W-1:0]  s1_prior,
   input  mvma_pkg::row_tag_type               s1_tag,
   input  wire  signed [mvma_pkg::DATA_W-1:0]  vec_data,
   output logic                                fin_valid_ff,
   output logic signed [mvma_pkg::ACC_W-1:0]   fin_acc_ff,
   output logic signed [mvma_pkg::DATA_W-1:0]  fin_prior_ff,
   output mvma_pkg::row_tag_type               fin_tag_ff
);
   import mvma_pkg::*;

   logic                     s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0] s2_prior_ff;
   row_tag_type              s2_tag_ff;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  acc_sum;
   logic                     fin_valid_in;

   assign s2_valid_in = s1_valid;
   assign prod_in     = s1_value * vec_data;

   // Product wraps into the accumulator modulo 2^48
   assign acc_sum      = acc_ff + ACC_W'(prod_ff);
   assign fin_valid_in = s2_valid_ff && s2_tag_ff.row_end;

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = s2_tag_ff.row_end ? '0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else if (advance) begin
         s2_valid_ff  <= s2_valid_in;
         fin_valid_ff <= fin_valid_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff      <= prod_in;
         s2_prior_ff  <= s1_prior;
         s2_tag_ff    <= s1_tag;
         fin_acc_ff   <= acc_sum;
         fin_prior_ff <= s2_prior_ff;
         fin_tag_ff   <= s2_tag_ff;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mvma_finish.sv =====
// ----------------------------------------------------------------------------
// mvma_finish
// Scale a finished row sum by alpha, add beta times the prior result,
// saturate, and hold the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mvma_finish (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  wire  signed [mvma_pkg::DATA_W-1:0]  alpha_scale,
   input  wire  signed [mvma_pkg::DATA_W-1:0]  beta_scale,
   input  wire                                 fin_valid,
   input  wire  signed [mvma_pkg::ACC_W-1:0]   fin_acc,
   input  wire  signed [mvma_pkg::DATA_W-1:0]  fin_prior,
   input  mvma_pkg::row_tag_type               fin_tag,
   output logic                                out_valid_ff,
   output logic signed [mvma_pkg::DATA_W-1:0]  out_y_ff,
   output logic        [mvma_pkg::ROW_W-1:0]   out_row_ff,
   output logic                                out_last_ff,
   output logic                                out_sat_ff
);
   import mvma_pkg::*;

   localparam int HI_W   = ACC_W - 16;
   localparam int PHI_W  = DATA_W + HI_W;
   localparam int PLO_W  = DATA_W + 17;
   localparam int PB_W   = 2 * DATA_W;
   localparam int SUM_W  = PHI_W + 1;
   localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'(2 ** (DATA_W - 1) - 1);
   localparam logic signed [SUM_W-1:0] Y_MIN = -Y_MAX - SUM_W'(1);

   logic signed [HI_W-1:0]   acc_hi;
   logic signed [16:0]       acc_lo;
   logic                     s4_valid_ff;
   row_tag_type              s4_tag_ff;
   logic signed [PHI_W-1:0]  p_hi_ff, p_hi_in;
   logic signed [PLO_W-1:0]  p_lo_ff, p_lo_in;
   logic signed [PB_W-1:0]   p_beta_ff, p_beta_in;
   logic signed [SUM_W-1:0]  sum;
   logic                     sat_hi, sat_lo;
   logic signed [DATA_W-1:0] out_y_in;
   logic                     out_sat_in;

   // Split the sum so alpha*acc needs only 16x32 and 16x17 multipliers
   assign acc_hi    = fin_acc[ACC_W-1:16];
   assign acc_lo    = $signed({1'b0, fin_acc[15:0]});
   assign p_hi_in   = alpha_scale * acc_hi;
   assign p_lo_in   = alpha_scale * acc_lo;
   assign p_beta_in = beta_scale * fin_prior;

   // Arithmetic shifts round toward minus infinity
   assign sum = SUM_W'(p_hi_ff) + SUM_W'(p_lo_ff >>> 16) + SUM_W'(p_beta_ff >>> 8);

   assign sat_hi     = sum > Y_MAX;
   assign sat_lo     = sum < Y_MIN;
   assign out_sat_in = sat_hi || sat_lo;

   always_comb begin
      out_y_in = sum[DATA_W-1:0];
      if (sat_hi) begin
         out_y_in = Y_MAX[DATA_W-1:0];
      end else if (sat_lo) begin
         out_y_in = Y_MIN[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff  <= fin_valid;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_hi_ff     <= p_hi_in;
         p_lo_ff     <= p_lo_in;
         p_beta_ff   <= p_beta_in;
         s4_tag_ff   <= fin_tag;
         out_y_ff    <= out_y_in;
         out_sat_ff  <= out_sat_in;
         out_row_ff  <= s4_tag_ff.row;
         out_last_ff <= s4_tag_ff.last;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/matrix_vector_multiply_accumulate.sv =====
// Matrix-vector multiply-accumulate, y = alpha*A*x + beta*y in signed Q8.8.
// Request channel (req_*): tuser 0 loads x[index] into the vector store,
// tuser 1 streams one element of the row-major matrix A. Every element is
// multiplied by x of its column and summed exactly in a 48-bit accumulator.
// The element that closes a row carries prior_y, the old y of that row, and
// produces one transfer on the response channel (rsp_*): the new y, its row,
// tlast on the final row of a pass, tuser when the result was clamped.
// Configuration (csr_*): row count, column count, alpha and beta; the user
// is to write them only while the block is idle, which the block leaves unchecked; always ready.
// Throughput: one request per cycle while no result waits on rsp, set by the
// single store read port and the one multiply-accumulate each element needs.
// A row result passes stage 1, s2, fin, s4 and the output register to rsp.
// Reset clears positions, accumulator and pipeline valid bits and loads the
// register defaults; the vector store holds no defined value until loaded.
// When rsp_tready stays low with a result waiting, the whole pipeline holds
// and req_tready drops until the result transfers.
// ----------------------------------------------------------------------------
// matrix_vector_multiply_accumulate
// Top level: handshakes, configuration, row and column positions, store read.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_vector_multiply_accumulate #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // Request: [9:0] index, [25:10] value, [41:26] prior_y, [47:42] zero
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [mvma_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  wire                                    req_tuser,  // [0] mode
   // Response: [15:0] y_value, [25:16] row_index, [31:26] zero
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [mvma_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser,  // [0] saturated
   // Configuration writes
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [mvma_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [mvma_pkg::DATA_W-1:0]            csr_data
);
   import mvma_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // Request fields
   logic [IDX_W-1:0]         req_index;
   logic signed [DATA_W-1:0] req_value;
   logic signed [DATA_W-1:0] req_prior;
   logic                     req_transfer;
   logic                     advance;

   // Configuration registers
   logic [COUNT_W-1:0]       row_count_ff, row_count_in;
   logic [COUNT_W-1:0]       col_count_ff, col_count_in;
   logic signed [DATA_W-1:0] alpha_ff, alpha_in;
   logic signed [DATA_W-1:0] beta_ff, beta_in;

   // Positions
   logic [CW-1:0]            col_pos_ff, col_pos_in;
   logic [RW-1:0]            row_pos_ff, row_pos_in;
   logic [31:0]              cols_eff, rows_eff;
   logic                     row_end, pass_end;
   logic                     matrix_item;

   // First pipeline stage
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [DATA_W-1:0] s1_value_ff, s1_prior_ff;
   row_tag_type              s1_tag_ff, s1_tag_in;
   logic [DATA_W-1:0]        vec_data;

   // Downstream connections
   logic                     fin_valid;
   logic signed [ACC_W-1:0]  fin_acc;
   logic signed [DATA_W-1:0] fin_prior;
   row_tag_type              fin_tag;
   logic signed [DATA_W-1:0] out_y;
   logic [ROW_W-1:0]         out_row;
   logic                     out_last, out_sat;

   assign req_index = req_tdata[IDX_W-1:0];
   assign req_value = req_tdata[IDX_W +: DATA_W];
   assign req_prior = req_tdata[IDX_W + DATA_W +: DATA_W];

   // Stall every stage while a finished result waits on the receiver
   assign advance      = !rsp_tvalid || rsp_tready;
   assign req_tready   = advance;
   assign req_transfer = req_tvalid && req_tready;
   assign matrix_item  = req_transfer && (req_tuser == MODE_MATRIX);

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_COUNT:    row_count_in = csr_data[COUNT_W-1:0];
            CSR_COLUMN_COUNT: col_count_in = csr_data[COUNT_W-1:0];
            CSR_ALPHA_SCALE:  alpha_in     = csr_data;
            CSR_BETA_SCALE:   beta_in      = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= COUNT_W'(1);
         col_count_ff <= COUNT_W'(1);
         alpha_ff     <= DATA_W'(256);
         beta_ff      <= '0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
      end
   end

   // ------------------------------------------------------------- positions
   // A count of zero acts as one; a count above the maximum acts as the maximum
   always_comb begin
      cols_eff = 32'(col_count_ff);
      if (col_count_ff == '0) begin
         cols_eff = 32'd1;
      end else if (32'(col_count_ff) > 32'(MAX_COLUMNS)) begin
         cols_eff = 32'(MAX_COLUMNS);
      end
      rows_eff = 32'(row_count_ff);
      if (row_count_ff == '0) begin
         rows_eff = 32'd1;
      end else if (32'(row_count_ff) > 32'(MAX_ROWS)) begin
         rows_eff = 32'(MAX_ROWS);
      end
   end

   // A position left at or past its count by a config change ends at once
   assign row_end  = (32'(col_pos_ff) + 32'd1) >= cols_eff;
   assign pass_end = (32'(row_pos_ff) + 32'd1) >= rows_eff;

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (matrix_item) begin
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = pass_end ? '0 : row_pos_ff + RW'(1);
         end else begin
            col_pos_in = col_pos_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // ----------------------------------------------------- store and stage 1
   // A load writes at its transfer edge; a later element reads the new word
   mvma_store #(
      .DEPTH (MAX_COLUMNS)
   ) u_store (
      .clock      (clock),
      .wr_en      (req_transfer && (req_tuser == MODE_LOAD) &&
                   (32'(req_index) < 32'(MAX_COLUMNS))),
      .wr_addr    (CW'(req_index)),
      .wr_data    (req_value),
      .rd_en      (matrix_item),
      .rd_addr    (col_pos_ff),
      .rd_data_ff (vec_data)
   );

   assign s1_valid_in       = matrix_item;
   assign s1_tag_in.row_end = row_end;
   assign s1_tag_in.last    = pass_end;
   assign s1_tag_in.row     = ROW_W'(row_pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_value_ff <= req_value;
         s1_prior_ff <= req_prior;
         s1_tag_ff   <= s1_tag_in;
      end
   end

   // ---------------------------------------------------- accumulate, finish
   mvma_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .s1_valid     (s1_valid_ff),
      .s1_value     (s1_value_ff),
      .s1_prior     (s1_prior_ff),
      .s1_tag       (s1_tag_ff),
      .vec_data     ($signed(vec_data)),
      .fin_valid_ff (fin_valid),
      .fin_acc_ff   (fin_acc),
      .fin_prior_ff (fin_prior),
      .fin_tag_ff   (fin_tag)
   );

   mvma_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .alpha_scale  (alpha_ff),
      .beta_scale   (beta_ff),
      .fin_valid    (fin_valid),
      .fin_acc      (fin_acc),
      .fin_prior    (fin_prior),
      .fin_tag      (fin_tag),
      .out_valid_ff (rsp_tvalid),
      .out_y_ff     (out_y),
      .out_row_ff   (out_row),
      .out_last_ff  (out_last),
      .out_sat_ff   (out_sat)
   );

   assign rsp_tdata = {(RSP_TDATA_W - DATA_W - ROW_W)'(0), out_row, out_y};
   assign rsp_tlast = out_last;
   assign rsp_tuser = out_sat;

endmodule

`default_nettype wire

// ===== hdl/mvma_checker.sv =====
// ----------------------------------------------------------------------------
// mvma_checker
// Port-level checks of the matrix-vector multiply-accumulate block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_vector_multiply_accumulate_defines.svh"

module mvma_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire [mvma_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input wire                                req_tuser,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [mvma_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire                                rsp_tlast,
   input wire                                rsp_tuser
);
   import mvma_pkg::*;

   // A stalled result holds until it transfers
   `MVMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser),
      "stalled response changed before transfer")

   // A waiting request holds until it transfers
   `MVMA_ASSERT_NEXT(a_req_hold, clock, reset, req_tvalid && !req_tready,
      req_tvalid && $stable(req_tdata) && $stable(req_tuser),
      "waiting request changed before transfer")

   // With no result waiting the pipeline must take requests
   `MVMA_ASSERT_SAME(a_req_open, clock, reset, !rsp_tvalid, req_tready,
      "request blocked while output register is empty")

   // A clamped result sits exactly at one end of the range
   `MVMA_ASSERT_SAME(a_sat_value, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata[DATA_W-1:0] == 16'h7fff || rsp_tdata[DATA_W-1:0] == 16'h8000,
      "saturation flag set on an unclamped value")

endmodule

bind matrix_vector_multiply_accumulate mvma_checker u_mvma_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams vector loads and row-major matrix elements into the matrix-vector
// multiply-accumulate block and checks every row result against a predictor
// that tracks the vector store, accumulator, positions and scale registers.
// ----------------------------------------------------------------------------

module testbench;
   import mvma_pkg::*;

   localparam int STORE_DEPTH      = 1024;  // MAX_COLUMNS of the block
   localparam int ROW_LIMIT        = 1024;  // MAX_ROWS of the block
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT      = 4000;
   localparam int RANDOM_ITEMS     = 1700;
   localparam longint Y_MAX        = (longint'(1) <<< (DATA_W - 1)) - 1;
   localparam longint Y_MIN        = -(longint'(1) <<< (DATA_W - 1));

   // One request transfer
   typedef struct packed {
      logic                     mode;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prior_y;
   } gemv_element_type;

   // One response transfer
   typedef struct packed {
      logic signed [DATA_W-1:0] y_value;
      logic [ROW_W-1:0]         row_index;
      logic                     last;
      logic                     saturated;
   } row_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [DATA_W-1:0]      csr_data   = '0;

   matrix_vector_multiply_accumulate DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 2 ns period: invert every half period
   always #1 clock = ~clock;

   // Requests waiting to be driven, row results waiting to be seen
   gemv_element_type pending_elements [$];
   row_result_type   expected_rows [$];

   int error_count  = 0;
   int quiet_cycles = 0;

   // Idling controls, set per phase by the stimulus process
   bit sender_gaps       = 1'b1;
   bit receiver_stalls   = 1'b1;
   int long_holds_asked  = 0;
   int long_holds_done   = 0;

   // Predictor state: store, accumulator, positions and register copies
   logic signed [DATA_W-1:0] x_model [STORE_DEPTH];
   logic signed [ACC_W-1:0]  acc_model;
   int                       col_model;
   int                       row_model;
   logic [COUNT_W-1:0]       rows_reg;
   logic [COUNT_W-1:0]       cols_reg;
   logic signed [DATA_W-1:0] alpha_reg;
   logic signed [DATA_W-1:0] beta_reg;

   // Stimulus-side view: which store entries hold data, where the column is
   bit x_loaded [STORE_DEPTH];
   int gen_col    = 0;
   int gen_cols   = 1;
   int items_sent = 0;

   // A count of zero acts as one, anything above the maximum as the maximum
   function automatic int effective_count(logic [COUNT_W-1:0] c, int maxv);
      if (c == '0) return 1;
      if (int'(c) > maxv) return maxv;
      return int'(c);
   endfunction

   // Gap length: mostly short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Q8.8 operand with extra weight on the extremes, zero and small values
   function automatic logic signed [DATA_W-1:0] rand_q88();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return '0;
         3, 4: return DATA_W'($urandom_range(0, 1023)) - 16'd512;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Alpha or beta: extremes, 1.0, -1.0, zero, small or anything
   function automatic logic [DATA_W-1:0] scale_word();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0100;
         3: return '0;
         4: return 16'hFF00;
         5: return DATA_W'($urandom_range(0, 63)) - 16'd32;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Count register word; the unused upper bits sometimes carry junk
   function automatic logic [DATA_W-1:0] count_word(int unsigned n);
      logic [DATA_W-1:0] w;
      w = DATA_W'($urandom);
      w[COUNT_W-1:0] = n[COUNT_W-1:0];
      if ($urandom_range(0, 3) != 0) w[DATA_W-1:COUNT_W] = '0;
      return w;
   endfunction

   // Advance the predictor by one accepted request
   task automatic predict_gemv_element(gemv_element_type e);
      longint         sum;
      longint         y_full;
      row_result_type r;
      int             cols;
      int             rows;
      cols = effective_count(cols_reg, STORE_DEPTH);
      rows = effective_count(rows_reg, ROW_LIMIT);
      if (e.mode == MODE_LOAD) begin
         x_model[e.index] = e.value;
         return;
      end
      // exact Q16.16 product into a wrapping 48-bit sum
      if (col_model < STORE_DEPTH) begin
         sum = longint'(acc_model) + longint'(e.value) * longint'(x_model[col_model]);
         acc_model = sum[ACC_W-1:0];
      end
      if (col_model + 1 < cols) begin
         col_model++;
         return;
      end
      // row closes: scale, add beta*prior_y, floor shifts, clamp
      y_full = ((longint'(alpha_reg) * longint'(acc_model)) >>> 16)
             + ((longint'(beta_reg) * longint'(e.prior_y)) >>> 8);
      r.saturated = 1'b0;
      if (y_full > Y_MAX) begin
         y_full = Y_MAX;
         r.saturated = 1'b1;
      end
      if (y_full < Y_MIN) begin
         y_full = Y_MIN;
         r.saturated = 1'b1;
      end
      r.y_value   = y_full[DATA_W-1:0];
      r.row_index = row_model[ROW_W-1:0];
      r.last      = (row_model + 1 >= rows);
      expected_rows.push_back(r);
      acc_model = '0;
      col_model = 0;
      row_model = r.last ? 0 : row_model + 1;
   endtask

   // ------------------------------------------------------------------------
   // Monitor: track register writes, predict on each request transfer and
   // compare each response transfer with the oldest expected row result.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      gemv_element_type taken;
      row_result_type   got;
      row_result_type   want;
      if (reset) begin
         acc_model    = '0;
         col_model    = 0;
         row_model    = 0;
         rows_reg     = 11'd1;
         cols_reg     = 11'd1;
         alpha_reg    = 16'sd256;
         beta_reg     = 16'sd0;
         quiet_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ROW_COUNT:    rows_reg  = csr_data[COUNT_W-1:0];
               CSR_COLUMN_COUNT: cols_reg  = csr_data[COUNT_W-1:0];
               CSR_ALPHA_SCALE:  alpha_reg = csr_data;
               CSR_BETA_SCALE:   beta_reg  = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            taken.mode    = req_tuser;
            taken.index   = req_tdata[IDX_W-1:0];
            taken.value   = req_tdata[IDX_W +: DATA_W];
            taken.prior_y = req_tdata[IDX_W + DATA_W +: DATA_W];
            predict_gemv_element(taken);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.y_value   = rsp_tdata[DATA_W-1:0];
            got.row_index = rsp_tdata[DATA_W +: ROW_W];
            got.last      = rsp_tlast;
            got.saturated = rsp_tuser;
            if (expected_rows.size() == 0) begin
               $display("%0t: row result with none expected: y=%0d row=%0d",
                        $time, got.y_value, got.row_index);
               error_count++;
            end else begin
               want = expected_rows.pop_front();
               if (got.y_value !== want.y_value) begin
                  $display("%0t: y_value mismatch row %0d: expected %0d actual %0d",
                           $time, want.row_index, want.y_value, got.y_value);
                  error_count++;
               end
               if (got.row_index !== want.row_index) begin
                  $display("%0t: row_index mismatch: expected %0d actual %0d",
                           $time, want.row_index, got.row_index);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: tlast mismatch row %0d: expected %0b actual %0b",
                           $time, want.row_index, want.last, got.last);
                  error_count++;
               end
               if (got.saturated !== want.saturated) begin
                  $display("%0t: saturated mismatch row %0d: expected %0b actual %0b",
                           $time, want.row_index, want.saturated, got.saturated);
                  error_count++;
               end
            end
         end
         // watchdog counts cycles in which no channel moves a transfer
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
               || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: take the next pending element once the slot is free,
   // with random gaps between elements when the phase allows them.
   // ------------------------------------------------------------------------
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      gemv_element_type next_element;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_elements.size() != 0) begin
            next_element = pending_elements.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_element.mode;
            req_tdata  <= {{(REQ_TDATA_W - IDX_W - 2 * DATA_W){1'b0}},
                           next_element.prior_y, next_element.value, next_element.index};
            if (sender_gaps && $urandom_range(0, 2) == 0) send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response receiver: random stalls, plus a long hold whenever the
   // stimulus asks for one, so results back up and the input stalls.
   // ------------------------------------------------------------------------
   int unsigned rsp_hold = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (long_holds_done != long_holds_asked) begin
         long_holds_done++;
         rsp_hold = LONG_HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
         rsp_hold = pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run when nothing has moved for too long
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_element(logic mode, int idx, logic signed [DATA_W-1:0] v,
                               logic signed [DATA_W-1:0] p);
      gemv_element_type e;
      e.mode    = mode;
      e.index   = idx[IDX_W-1:0];
      e.value   = v;
      e.prior_y = p;
      pending_elements.push_back(e);
      items_sent++;
   endtask

   task automatic load_x(int idx, logic signed [DATA_W-1:0] v);
      x_loaded[idx] = 1'b1;
      push_element(MODE_LOAD, idx, v, rand_q88());
   endtask

   // Queue one matrix element; load x of its column first if never written,
   // so the block never reads an undefined store entry
   task automatic stream_a(logic signed [DATA_W-1:0] v, logic signed [DATA_W-1:0] p);
      if (gen_col < STORE_DEPTH && !x_loaded[gen_col]) load_x(gen_col, rand_q88());
      push_element(MODE_MATRIX, $urandom_range(0, STORE_DEPTH - 1), v, p);
      gen_col = (gen_col + 1 < gen_cols) ? gen_col + 1 : 0;
   endtask

   task automatic write_reg(csr_index_type idx, logic [DATA_W-1:0] d);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_COLUMN_COUNT) gen_cols = effective_count(d[COUNT_W-1:0], STORE_DEPTH);
   endtask

   // Wait until every element is sent and every result seen, then let a
   // partial row's last element clear the pipeline
   task automatic settle();
      do @(negedge clock);
      while (pending_elements.size() != 0 || req_tvalid || expected_rows.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: directed corners, a back-pressure phase, then random phases
   // with fresh register settings between them.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned phase_len;
      int          random_start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one row of one column, alpha 1.0, beta 0
      load_x(0, 16'h7FFF);
      load_x(STORE_DEPTH - 1, 16'h8000);
      stream_a(16'h7FFF, rand_q88());
      stream_a(16'h8000, 16'h7FFF);
      stream_a(16'h0001, 16'h8000);
      settle();

      // largest positive products with alpha at its top: clamp high
      write_reg(CSR_ROW_COUNT, 16'd3);
      write_reg(CSR_COLUMN_COUNT, 16'd4);
      write_reg(CSR_ALPHA_SCALE, 16'h7FFF);
      write_reg(CSR_BETA_SCALE, 16'h8000);
      for (int i = 0; i < 4; i++) load_x(i, 16'h8000);
      repeat (4) stream_a(16'h8000, 16'h7FFF);
      // leave row 1 half done
      repeat (2) stream_a(16'h7FFF, rand_q88());
      settle();

      // shrink both counts below the live positions: next element ends the
      // row, and that row ends the pass
      write_reg(CSR_COLUMN_COUNT, 16'd2);
      write_reg(CSR_ROW_COUNT, 16'd1);
      repeat (3) stream_a(rand_q88(), rand_q88());
      settle();

      // zero column count acts as one, oversized row count as the maximum;
      // most negative alpha drives the first result to the low clamp
      write_reg(CSR_ALPHA_SCALE, 16'h8000);
      write_reg(CSR_BETA_SCALE, 16'h7FFF);
      write_reg(CSR_COLUMN_COUNT, 16'd0);
      write_reg(CSR_ROW_COUNT, 16'hFFFF);
      stream_a(16'h8000, 16'h8000);
      stream_a(16'h7FFF, 16'h7FFF);
      stream_a(16'h0000, 16'h7FFF);
      settle();

      // alpha zero, beta 1.0: result is prior_y
      write_reg(CSR_ALPHA_SCALE, 16'h0000);
      write_reg(CSR_BETA_SCALE, 16'h0100);
      stream_a(rand_q88(), 16'h8000);
      stream_a(rand_q88(), 16'h7FFF);
      settle();

      // back-pressure: one result per element, sender never idles, receiver
      // holds off long enough for the block to fill and stall its input
      write_reg(CSR_COLUMN_COUNT, 16'd1);
      write_reg(CSR_ROW_COUNT, 16'd5);
      write_reg(CSR_ALPHA_SCALE, 16'h0100);
      write_reg(CSR_BETA_SCALE, scale_word());
      sender_gaps = 1'b0;
      long_holds_asked++;
      repeat (150) stream_a(rand_q88(), rand_q88());
      settle();
      sender_gaps = 1'b1;

      // random phases: mostly whole rows with random content, some stray
      // loads, and phases cut mid-row before the next settings
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
               0: write_reg(CSR_ROW_COUNT, count_word(0));
               1: write_reg(CSR_ROW_COUNT, count_word(1));
               2, 3: write_reg(CSR_ROW_COUNT, count_word($urandom_range(2, 6)));
               4: write_reg(CSR_ROW_COUNT, count_word($urandom_range(7, 40)));
               5: write_reg(CSR_ROW_COUNT, count_word($urandom_range(0, 1) ? 1024 : 2047));
               default: write_reg(CSR_ROW_COUNT, count_word($urandom_range(0, 2047)));
            endcase
         end
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 19))
               0: write_reg(CSR_COLUMN_COUNT, count_word(0));
               1, 2: write_reg(CSR_COLUMN_COUNT, count_word(1));
               15, 16, 17, 18:
                  write_reg(CSR_COLUMN_COUNT, count_word($urandom_range(9, 32)));
               19: write_reg(CSR_COLUMN_COUNT, count_word($urandom_range(33, 2047)));
               default: write_reg(CSR_COLUMN_COUNT, count_word($urandom_range(2, 8)));
            endcase
         end
         if ($urandom_range(0, 1) == 0) write_reg(CSR_ALPHA_SCALE, scale_word());
         if ($urandom_range(0, 1) == 0) write_reg(CSR_BETA_SCALE, scale_word());
         sender_gaps     = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(20, 120);
         repeat (phase_len) begin
            if ($urandom_range(0, 9) == 0)
               load_x($urandom_range(0, STORE_DEPTH - 1), rand_q88());
            else
               stream_a(rand_q88(), rand_q88());
         end
         settle();
      end

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
